// ----- rtl/abc_pkg.sv -----
// types and constants shared by the destination-over compositing pipeline
// no dependencies
`default_nettype none
package abc_pkg;

	localparam int CH_W   = 16;
	localparam int DEN_W  = 31;
	localparam int NUM_W  = 47;
	localparam int QBITS  = 16;
	localparam int SH_W   = 4;

	localparam logic [CH_W-1:0] NARROW_MAX = 16'd255;
	localparam logic [CH_W-1:0] WIDE_MAX   = 16'd32768;

	localparam logic [1:0] SEL_SRC = 2'd0;
	localparam logic [1:0] SEL_DST = 2'd1;
	localparam logic [1:0] SEL_MIX = 2'd2;

	typedef logic [CH_W-1:0]  ch_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;

	typedef struct packed {
		ch_t src_alpha;
		ch_t src_red;
		ch_t src_green;
		ch_t src_blue;
		ch_t dst_alpha;
		ch_t dst_red;
		ch_t dst_green;
		ch_t dst_blue;
	} in_pix_t;

	typedef struct packed {
		ch_t out_alpha;
		ch_t out_red;
		ch_t out_green;
		ch_t out_blue;
	} out_pix_t;

	// what rides alongside the divider
	typedef struct packed {
		logic [1:0]      sel;
		ch_t             m;
		logic [3:0][CH_W-1:0] byp;
	} side_t;

	// lanes 0..2 are red, green, blue
	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][DEN_W-1:0] dvs;
		logic [2:0][CH_W-1:0]  quo;
	} div_t;

	function automatic ch_t sat(input ch_t v, input ch_t m);
		return (v > m) ? m : v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/abc_front.sv -----
// front stages: saturation, weights, products, numerators and alpha
// depends on abc_pkg
`default_nettype none
module abc_front import abc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire logic    wide,
	input  wire logic    up_valid,
	input  wire in_pix_t up_pix,
	output logic         dn_valid,
	output side_t        dn_side,
	output div_t         dn_work
);

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic [7:0][CH_W-1:0]  p_s1;
	ch_t                   md_s1;
	side_t                 side_s1, side_s2, side_s3, side_s4;
	logic [2:0][CH_W-1:0]  s_s2, d_s2;
	logic [DEN_W-1:0]      ws_s2, wd_s2;
	logic [2:0][NUM_W-1:0] ps_s3, pd_s3;
	den_t                  den_s3;
	div_t                  work_s4;

	ch_t                   m;
	logic [7:0][CH_W-1:0]  p;
	logic [1:0]            sel;
	logic [16:0]           q255;
	ch_t                   alpha;
	side_t                 side_nx;

	always_comb begin
		m = wide ? WIDE_MAX : NARROW_MAX;
		p[0] = sat(up_pix.src_alpha, m);
		p[1] = sat(up_pix.src_red, m);
		p[2] = sat(up_pix.src_green, m);
		p[3] = sat(up_pix.src_blue, m);
		p[4] = sat(up_pix.dst_alpha, m);
		p[5] = sat(up_pix.dst_red, m);
		p[6] = sat(up_pix.dst_green, m);
		p[7] = sat(up_pix.dst_blue, m);
		if (p[4] == '0) begin
			sel = SEL_SRC;
		end else if (p[0] == '0 || p[4] == m) begin
			sel = SEL_DST;
		end else begin
			sel = SEL_MIX;
		end
	end

	// alpha = den / m: a shift for 32768, add-and-shift for 255 (den < 65280 there)
	always_comb begin
		q255    = den_s3[16:0] + 17'd1 + {8'd0, den_s3[16:8]};
		alpha   = (side_s3.m == WIDE_MAX) ? den_s3[30:15] : {7'd0, q255[16:8]};
		side_nx = side_s3;
		if (side_s3.sel == SEL_MIX) begin
			side_nx.byp[0] = alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1        <= p;
			md_s1       <= m - p[4];
			side_s1.sel <= sel;
			side_s1.m   <= m;
			for (int i = 0; i < 4; i++) begin
				side_s1.byp[i] <= (sel == SEL_SRC) ? p[i] : p[4+i];
			end

			ws_s2   <= DEN_W'(p_s1[0]) * DEN_W'(md_s1);
			wd_s2   <= DEN_W'(p_s1[4]) * DEN_W'(side_s1.m);
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				s_s2[i] <= p_s1[1+i];
				d_s2[i] <= p_s1[5+i];
			end

			for (int i = 0; i < 3; i++) begin
				ps_s3[i] <= NUM_W'(s_s2[i]) * NUM_W'(ws_s2);
				pd_s3[i] <= NUM_W'(d_s2[i]) * NUM_W'(wd_s2);
			end
			den_s3  <= ws_s2 + wd_s2;
			side_s3 <= side_s2;

			for (int i = 0; i < 3; i++) begin
				work_s4.rem[i] <= ps_s3[i] + pd_s3[i];
				work_s4.dvs[i] <= den_s3;
				work_s4.quo[i] <= '0;
			end
			side_s4 <= side_nx;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_side  = side_s4;
	assign dn_work  = work_s4;

endmodule
`default_nettype wire

// ----- rtl/abc_div_stage.sv -----
// one restoring-division step for the three color lanes, one register stage
// depends on abc_pkg
`default_nettype none
module abc_div_stage import abc_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic [SH_W-1:0] shift,
	input  wire logic            up_valid,
	input  wire side_t           up_side,
	input  wire div_t            up_work,
	output logic                 dn_valid,
	output side_t                dn_side,
	output div_t                 dn_work
);

	logic  valid_q;
	side_t side_q;
	div_t  work_q;
	div_t  nxt;
	num_t  trial;

	always_comb begin
		nxt   = up_work;
		trial = '0;
		for (int i = 0; i < 3; i++) begin
			trial = NUM_W'(up_work.dvs[i]) << shift;
			if (up_work.rem[i] >= trial) begin
				nxt.rem[i]        = up_work.rem[i] - trial;
				nxt.quo[i][shift] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q <= up_side;
			work_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_side  = side_q;
	assign dn_work  = work_q;

endmodule
`default_nettype wire

// ----- rtl/alpha_behind_composite_core.sv -----
// top level: config register, front stages, divider chain, output register
// depends on abc_pkg, abc_front, abc_div_stage
`default_nettype none
// Composites a source ARGB pixel behind a destination pixel (destination-over),
// with channel maximum 255 or 32768 picked by the config register wide_q (wr_data).
// One pixel is accepted per clock while pix_stall is low; the pipeline has four front stages
// (saturate, weights, products, sums and alpha), sixteen one-bit division stages
// for the three colors, and the output register. A stall on the
// result side freezes the whole pipeline and is passed back on pix_stall.
module alpha_behind_composite_core import abc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_en,
	input  wire logic    wr_data,
	input  wire logic    pix_valid,
	output logic         pix_stall,
	input  wire in_pix_t pix,
	output logic         res_valid,
	input  wire logic    res_stall,
	output out_pix_t     res
);

	logic     wide_q;
	logic     adv;
	logic     res_valid_q;
	out_pix_t res_q;

	logic               v_chain [QBITS+1];
	side_t              s_chain [QBITS+1];
	div_t               w_chain [QBITS+1];
	logic [3:0][CH_W-1:0] fin;

	assign adv       = !(res_valid_q && res_stall);
	assign pix_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (wr_en) begin
			wide_q <= wr_data;
		end
	end

	abc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.wide     (wide_q),
		.up_valid (pix_valid),
		.up_pix   (pix),
		.dn_valid (v_chain[0]),
		.dn_side  (s_chain[0]),
		.dn_work  (w_chain[0])
	);

	for (genvar g = 0; g < QBITS; g++) begin : g_div
		abc_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.shift    (SH_W'(QBITS - 1 - g)),
			.up_valid (v_chain[g]),
			.up_side  (s_chain[g]),
			.up_work  (w_chain[g]),
			.dn_valid (v_chain[g+1]),
			.dn_side  (s_chain[g+1]),
			.dn_work  (w_chain[g+1])
		);
	end

	// alpha comes ready from the front stages
	always_comb begin
		fin[0] = s_chain[QBITS].byp[0];
		for (int i = 0; i < 3; i++) begin
			if (s_chain[QBITS].sel == SEL_MIX) begin
				fin[1+i] = sat(w_chain[QBITS].quo[i], s_chain[QBITS].m);
			end else begin
				fin[1+i] = s_chain[QBITS].byp[1+i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_chain[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_alpha <= fin[0];
			res_q.out_red   <= fin[1];
			res_q.out_green <= fin[2];
			res_q.out_blue  <= fin[3];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire
